// ===== src/c2u_pkg.sv =====
// c2u_pkg: shared types, constants and charset tables for the transcoder
// no dependencies; compiled first
package c2u_pkg;

	localparam logic [2:0] MODE_ASCII   = 3'd0;
	localparam logic [2:0] MODE_UTF8    = 3'd1;
	localparam logic [2:0] MODE_LATIN1  = 3'd2;
	localparam logic [2:0] MODE_LATIN9  = 3'd3;
	localparam logic [2:0] MODE_CP1252  = 3'd4;

	localparam logic CFG_CHARSET_MODE     = 1'b0;
	localparam logic CFG_REPLACEMENT_CODE = 1'b1;

	localparam logic [30:0] REPL_RESET = 31'h0000FFFD;

	// one code point on its way to the encoder
	typedef struct packed {
		logic [30:0] code;
		logic        last;
	} code_item_t;

	// configuration as seen by the front end
	typedef struct packed {
		logic [2:0]  mode;
		logic [30:0] repl;
		logic        mode_wr;
	} cfg_view_t;

	// cp1252 bytes 0x80..0x9F, except that 0x95 maps to U+00B7; zero marks a hole
	localparam logic [15:0] CP_LOW [32] = '{
		16'h20ac, 16'h0000, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017d, 16'h0000,
		16'h0000, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h00b7, 16'h2013, 16'h2014,
		16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h0000, 16'h017e, 16'h0178
	};

	function automatic logic [15:0] table_map(input logic [7:0] b, input logic [2:0] mode);
		logic [15:0] r;
		r = {8'h00, b};
		if (b == 8'hAD) begin
			r = 16'h0000;
		end else if (b[7:5] == 3'b100) begin
			r = (mode == MODE_CP1252) ? CP_LOW[b[4:0]] : 16'h0000;
		end else if (mode == MODE_LATIN9) begin
			case (b)
				8'hA4: r = 16'h20ac;
				8'hA6: r = 16'h0160;
				8'hA8: r = 16'h0161;
				8'hB4: r = 16'h017d;
				8'hB8: r = 16'h017e;
				8'hBC: r = 16'h0152;
				8'hBD: r = 16'h0153;
				8'hBE: r = 16'h0178;
				default: r = {8'h00, b};
			endcase
		end
		return r;
	endfunction

	// sequence length announced by a lead byte, zero if not a lead
	function automatic logic [2:0] lead_need(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b[7:5] == 3'b110) n = 3'd2;
		else if (b[7:4] == 4'b1110) n = 3'd3;
		else if (b[7:3] == 5'b11110) n = 3'd4;
		else if (b[7:2] == 6'b111110) n = 3'd5;
		else if (b[7:1] == 7'b1111110) n = 3'd6;
		return n;
	endfunction

endpackage

// ===== src/c2u_if.sv =====
// c2u channel interfaces: text input, utf-8 output, configuration write
// no dependencies
interface c2u_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	modport source(output valid, text_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface c2u_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] utf8_byte;
	logic       run_last;
	modport source(output valid, utf8_byte, run_last, input ready);
	modport sink(input valid, utf8_byte, run_last, output ready);
endinterface

interface c2u_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [30:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/c2u_front.sv =====
// c2u_front: accepts text bytes, decodes the charset, issues code points
// depends on c2u_pkg
module c2u_front (
	input  logic                clk,
	input  logic                arst_n,
	input  c2u_pkg::cfg_view_t  cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                push_valid,
	input  logic                push_ready,
	output c2u_pkg::code_item_t push_item
);
	import c2u_pkg::*;

	logic [2:0]  held_q, need_q;
	logic [24:0] acc_q;
	logic        busy_q;
	logic [2:0]  rep_q;
	logic        main_v_q;
	logic [30:0] main_q;

	logic [2:0]  held_d, need_d, pre, post, need_new;
	logic [24:0] acc_d;
	logic        has_main;
	logic [30:0] main_d;
	logic [15:0] tmap;
	logic        accept, push_fire, push_is_last;

	assign accept = in_valid && in_ready;
	assign in_ready = !busy_q;

	always_comb begin
		held_d = held_q;
		need_d = need_q;
		acc_d = acc_q;
		pre = 3'd0;
		post = 3'd0;
		has_main = 1'b0;
		main_d = 31'd0;
		need_new = lead_need(in_byte);
		tmap = table_map(in_byte, cfg.mode);
		if (cfg.mode == MODE_UTF8) begin
			if (held_q != 3'd0 && in_byte[7:6] == 2'b10) begin
				if ({1'b0, held_q} + 4'd1 >= {1'b0, need_q}) begin
					has_main = 1'b1;
					main_d = {acc_q, in_byte[5:0]};
					held_d = 3'd0;
					need_d = 3'd0;
				end else begin
					acc_d = {acc_q[18:0], in_byte[5:0]};
					held_d = held_q + 3'd1;
				end
			end else begin
				pre = held_q;
				held_d = 3'd0;
				need_d = 3'd0;
				if (!in_byte[7]) begin
					has_main = 1'b1;
					main_d = {24'd0, in_byte[6:0]};
				end else if (need_new == 3'd0) begin
					has_main = 1'b1;
					main_d = cfg.repl;
				end else begin
					acc_d = {17'd0, in_byte & (8'h7F >> need_new)};
					held_d = 3'd1;
					need_d = need_new;
				end
			end
			// end of text flushes whatever is still pending
			if (in_last && held_d != 3'd0) begin
				post = held_d;
				held_d = 3'd0;
				need_d = 3'd0;
			end
		end else if (cfg.mode == MODE_LATIN1 || cfg.mode == MODE_LATIN9
			|| cfg.mode == MODE_CP1252) begin
			has_main = 1'b1;
			main_d = (tmap == 16'h0000 && in_byte != 8'h00) ? cfg.repl : {15'd0, tmap};
		end else begin
			has_main = 1'b1;
			main_d = {24'd0, in_byte[6:0]};
		end
	end

	assign push_valid = busy_q;
	assign push_fire = push_valid && push_ready;
	assign push_is_last = (rep_q == 3'd0) || (rep_q == 3'd1 && !main_v_q);
	assign push_item.code = (rep_q != 3'd0) ? cfg.repl : main_q;
	assign push_item.last = push_is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 3'd0;
			need_q <= 3'd0;
			busy_q <= 1'b0;
			rep_q <= 3'd0;
			main_v_q <= 1'b0;
		end else if (cfg.mode_wr) begin
			held_q <= 3'd0;
			need_q <= 3'd0;
		end else if (accept) begin
			held_q <= held_d;
			need_q <= need_d;
			rep_q <= pre + post;
			main_v_q <= has_main;
			busy_q <= has_main || (pre + post) != 3'd0;
		end else if (push_fire) begin
			if (rep_q != 3'd0) rep_q <= rep_q - 3'd1;
			else main_v_q <= 1'b0;
			if (push_is_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_d;
			main_q <= main_d;
		end
	end
endmodule

// ===== src/c2u_queue.sv =====
// c2u_queue: two-entry queue of code points between front and back end
// depends on c2u_pkg
module c2u_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  c2u_pkg::code_item_t push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output c2u_pkg::code_item_t pop_item
);
	import c2u_pkg::*;

	code_item_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end
endmodule

// ===== src/c2u_back.sv =====
// c2u_back: encodes code points into minimal utf-8, one byte per cycle while the output is ready
// depends on c2u_pkg
module c2u_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  c2u_pkg::code_item_t pop_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import c2u_pkg::*;

	logic        active_q, first_q, last_q;
	logic [30:0] code_q;
	logic [2:0]  rem_q;
	logic        ov_q, olast_q;
	logic [7:0]  obyte_q;

	logic        space, fire, done;
	logic [7:0]  gen_byte;
	logic [5:0]  cont_bits;
	logic [2:0]  nlen;

	assign space = !ov_q || out_ready;
	assign fire = active_q && space;
	assign done = fire && rem_q == 3'd1;
	assign pop_ready = !active_q || done;

	always_comb begin
		if (pop_item.code[30:7] == 24'd0) nlen = 3'd1;
		else if (pop_item.code[30:11] == 20'd0) nlen = 3'd2;
		else if (pop_item.code[30:16] == 15'd0) nlen = 3'd3;
		else if (pop_item.code[30:21] == 10'd0) nlen = 3'd4;
		else if (pop_item.code[30:26] == 5'd0) nlen = 3'd5;
		else nlen = 3'd6;
	end

	always_comb begin
		case (rem_q)
			3'd1: cont_bits = code_q[5:0];
			3'd2: cont_bits = code_q[11:6];
			3'd3: cont_bits = code_q[17:12];
			3'd4: cont_bits = code_q[23:18];
			3'd5: cont_bits = code_q[29:24];
			default: cont_bits = 6'd0;
		endcase
		if (!first_q) begin
			gen_byte = {2'b10, cont_bits};
		end else begin
			case (rem_q)
				3'd1: gen_byte = {1'b0, code_q[6:0]};
				3'd2: gen_byte = {3'b110, code_q[10:6]};
				3'd3: gen_byte = {4'b1110, code_q[15:12]};
				3'd4: gen_byte = {5'b11110, code_q[20:18]};
				3'd5: gen_byte = {6'b111110, code_q[25:24]};
				default: gen_byte = {7'b1111110, code_q[30]};
			endcase
		end
	end

	// after the lead, rem counts the continuation bytes still to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) active_q <= 1'b1;
			else if (done) active_q <= 1'b0;
			if (fire) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			code_q <= pop_item.code;
			last_q <= pop_item.last;
			rem_q <= nlen;
			first_q <= 1'b1;
		end else if (fire) begin
			rem_q <= first_q ? rem_q - 3'd1 : rem_q - 3'd1;
			first_q <= 1'b0;
		end
		if (fire) begin
			obyte_q <= gen_byte;
			olast_q <= last_q && rem_q == 3'd1;
		end
	end

	assign out_valid = ov_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;
endmodule

// ===== src/charset_to_utf8_transcoder.sv =====
// charset_to_utf8_transcoder: top level, configuration registers and wiring
// depends on c2u_pkg, c2u_if, c2u_front, c2u_queue, c2u_back
//
// Converts a byte stream in ascii, utf-8 (legacy 1 to 6 byte forms),
// iso8859-1, iso8859-15 or cp1252 into minimal utf-8, one output byte per
// transaction, with run_last on the final byte caused by each input byte.
// The front end takes one input byte, then issues each code point it has
// to produce (up to six when a broken sequence is flushed) and takes no new
// byte until all are pushed; an input byte that only extends a pending
// sequence issues none. The back end emits one output byte per cycle while
// the output is ready. A two-entry queue lets the front accept new bytes
// while the back end is still draining. Writing charset_mode drops any
// pending sequence; writes are expected only while idle.
module charset_to_utf8_transcoder (
	input logic       clk,
	input logic       arst_n,
	c2u_text_if.sink  in_ch,
	c2u_byte_if.source out_ch,
	c2u_cfg_if.sink   cfg_ch
);
	import c2u_pkg::*;

	logic [2:0]  mode_q;
	logic [30:0] repl_q;
	logic        cfg_fire;
	cfg_view_t   cfg;

	// front to queue
	logic       push_valid, push_ready;
	code_item_t push_item;
	// queue to back
	logic       pop_valid, pop_ready;
	code_item_t pop_item;

	// configuration always taken at once
	assign cfg_ch.ready = 1'b1;
	assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
			repl_q <= REPL_RESET;
		end else if (cfg_fire) begin
			case (cfg_ch.index)
				CFG_CHARSET_MODE:     mode_q <= cfg_ch.data[2:0];
				CFG_REPLACEMENT_CODE: repl_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.repl = repl_q;
	assign cfg.mode_wr = cfg_fire && cfg_ch.index == CFG_CHARSET_MODE;

	c2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_byte    (in_ch.text_byte),
		.in_last    (in_ch.end_of_text),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	c2u_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	c2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.utf8_byte),
		.out_last  (out_ch.run_last)
	);
endmodule
